/* rtl/sthi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthi_pkg: shared types and constants of the slope-to-height integrator
// Holds the configuration record, the controller/datapath command and status
// records, the sequencer codes and the tangent coefficient table.
// ----------------------------------------------------------------------------
package sthi_pkg;

  // Largest row the column counter has to cover.
  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned CNT_W     = $clog2(MAX_WIDTH);
  localparam int unsigned RW_W      = 13;
  localparam int unsigned STEP_W    = 20;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned SLOPE_W   = 16;
  localparam int unsigned HEIGHT_W  = 32;
  localparam int unsigned MAG_W     = SLOPE_W + 1;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned ANG_W     = 30;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned D_W       = 51;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // pi/4 in Q30
  localparam logic [ANG_W-1:0] PI4_Q30 = 30'd843314857;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_Y = 3'd4;

  // Register reset values
  localparam logic [RW_W-1:0]    RST_ROW_WIDTH   = 13'd256;
  localparam logic [STEP_W-1:0]  RST_STEP_X      = 20'd125000;
  localparam logic [STEP_W-1:0]  RST_STEP_Y      = 20'd125000;
  localparam logic [SCALE_W-1:0] RST_INV_SCALE_X = 32'd333062059;
  localparam logic [SCALE_W-1:0] RST_INV_SCALE_Y = 32'd20641550;

  typedef struct packed {
    logic [RW_W-1:0]    row_width;
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
    logic [SCALE_W-1:0] inv_scale_x;
    logic [SCALE_W-1:0] inv_scale_y;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_SUM,
    ST_FIN
  } state_e;

  // One multiply step of the sequence: angle, square, Horner, tangent, step.
  typedef enum logic [2:0] {
    OP_ANGLE,
    OP_SQUARE,
    OP_HORNER,
    OP_TAN,
    OP_STEP
  } op_e;

  typedef struct packed {
    logic       accept;
    logic       mul_en;
    logic       wb_en;
    logic       sum_en;
    logic       load_out;
    op_e        op;
    logic [2:0] coef_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
  } dp_status_t;

  // Odd Taylor coefficients of tan in Q30, from x^15 down to x^1.
  function automatic logic [ACC_W-1:0] tan_coef(input logic [2:0] k);
    logic [ACC_W-1:0] c;
    unique case (k)
      3'd0:    c = 32'd1563190;
      3'd1:    c = 32'd3857018;
      3'd2:    c = 32'd9516827;
      3'd3:    c = 32'd23482185;
      3'd4:    c = 32'd57947971;
      3'd5:    c = 32'd143165577;
      3'd6:    c = 32'd357913941;
      3'd7:    c = 32'd1073741824;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/sthi_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthi_ctrl: sequencer of the slope-to-height integrator
// Accepts one pixel at a time, steps the shared multiplier through the
// angle, tangent and increment, and loads the output register.
// ----------------------------------------------------------------------------
module sthi_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  sthi_pkg::dp_status_t  status_i,
  output sthi_pkg::ctrl_cmd_t   cmd_o
);

  sthi_pkg::state_e state_q, state_d;
  sthi_pkg::op_e    op_q, op_d;
  logic [2:0]       k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;

  assign in_stall_o  = (state_q != sthi_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sthi_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = status_i.skip ? sthi_pkg::ST_FIN : sthi_pkg::ST_MUL;
        end
      end
      sthi_pkg::ST_MUL: state_d = sthi_pkg::ST_WB;
      sthi_pkg::ST_WB: begin
        state_d = (op_q == sthi_pkg::OP_STEP) ? sthi_pkg::ST_SUM : sthi_pkg::ST_MUL;
      end
      sthi_pkg::ST_SUM: state_d = sthi_pkg::ST_FIN;
      sthi_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = sthi_pkg::ST_IDLE;
        end
      end
      default: state_d = sthi_pkg::ST_IDLE;
    endcase
  end

  // Advance the multiply sequence after each writeback
  always_comb begin
    op_d = op_q;
    k_d  = k_q;
    if (accept) begin
      op_d = sthi_pkg::OP_ANGLE;
      k_d  = '0;
    end else if (state_q == sthi_pkg::ST_WB) begin
      unique case (op_q)
        sthi_pkg::OP_ANGLE: op_d = sthi_pkg::OP_SQUARE;
        sthi_pkg::OP_SQUARE: begin
          op_d = sthi_pkg::OP_HORNER;
          k_d  = 3'd1;
        end
        sthi_pkg::OP_HORNER: begin
          if (k_q == 3'd7) begin
            op_d = sthi_pkg::OP_TAN;
          end else begin
            k_d = k_q + 3'd1;
          end
        end
        sthi_pkg::OP_TAN: op_d = sthi_pkg::OP_STEP;
        sthi_pkg::OP_STEP: op_d = sthi_pkg::OP_STEP;
        default: op_d = sthi_pkg::OP_ANGLE;
      endcase
    end
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op_q;
    cmd_o.coef_idx = k_q;
    cmd_o.accept   = accept;
    unique case (state_q)
      sthi_pkg::ST_IDLE: ;
      sthi_pkg::ST_MUL:  cmd_o.mul_en = 1'b1;
      sthi_pkg::ST_WB:   cmd_o.wb_en = 1'b1;
      sthi_pkg::ST_SUM:  cmd_o.sum_en = 1'b1;
      sthi_pkg::ST_FIN:  cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sthi_pkg::ST_IDLE;
      op_q        <= sthi_pkg::OP_ANGLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/sthi_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthi_datapath: row state, shared multiplier and height update
// Holds the raster position and the heights carried between pixels, and
// evaluates prev + step*tan(slope*scale) one multiply per command.
// ----------------------------------------------------------------------------
module sthi_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  sthi_pkg::cfg_t                          cfg_i,
  input  sthi_pkg::ctrl_cmd_t                     cmd_i,
  output sthi_pkg::dp_status_t                    status_o,
  input  logic signed [sthi_pkg::SLOPE_W-1:0]     x_slope_i,
  input  logic signed [sthi_pkg::SLOPE_W-1:0]     y_slope_i,
  input  logic                                    frame_start_i,
  output logic signed [sthi_pkg::HEIGHT_W-1:0]    height_o,
  output logic                                    row_end_o
);

  // Raster state
  logic [sthi_pkg::CNT_W-1:0]           column_count_q;
  logic                                 first_row_q;
  logic [sthi_pkg::SLOPE_W-1:0]         prev_x_slope_q;
  logic [sthi_pkg::SLOPE_W-1:0]         col0_y_slope_q;
  logic signed [sthi_pkg::HEIGHT_W-1:0] row_height_q;
  logic signed [sthi_pkg::HEIGHT_W-1:0] col0_height_q;

  // Per-pixel operands
  logic signed [sthi_pkg::HEIGHT_W-1:0] prev_q;
  logic                                 neg_q;
  logic [sthi_pkg::MAG_W-1:0]           mag_q;
  logic [sthi_pkg::STEP_W-1:0]          step_q;
  logic [sthi_pkg::SCALE_W-1:0]         scale_q;
  logic                                 zero_q;
  logic                                 col0_q;
  logic                                 last_q;

  // Intermediate results
  logic [sthi_pkg::PROD_W-1:0]          prod_q;
  logic [sthi_pkg::ANG_W-1:0]           a_q;
  logic [sthi_pkg::ANG_W-1:0]           x2_q;
  logic [sthi_pkg::ACC_W-1:0]           acc_q;
  logic [sthi_pkg::ACC_W-1:0]           t_q;
  logic [sthi_pkg::D_W-1:0]             d_q;
  logic signed [sthi_pkg::SUM_W-1:0]    sum_q;

  // Output register
  logic signed [sthi_pkg::HEIGHT_W-1:0] height_q;
  logic                                 row_end_q;

  logic [sthi_pkg::RW_W-1:0]            w_eff;
  logic [sthi_pkg::RW_W-1:0]            w_m1;
  logic [sthi_pkg::CNT_W-1:0]           col_eff;
  logic                                 first_eff;
  logic                                 is_col0;
  logic                                 last;
  logic [sthi_pkg::SLOPE_W-1:0]         slope_sel;
  logic [sthi_pkg::MUL_W-1:0]           mul_a;
  logic [sthi_pkg::MUL_W-1:0]           mul_b;
  logic [sthi_pkg::ANG_W:0]             a_raw;
  logic signed [sthi_pkg::SUM_W-1:0]    prev_sh;
  logic signed [sthi_pkg::SUM_W-1:0]    d_ext;
  logic signed [33:0]                   quot;
  logic signed [33:0]                   quot_adj;
  logic signed [sthi_pkg::HEIGHT_W-1:0] h_sat;
  logic signed [sthi_pkg::HEIGHT_W-1:0] h_new;

  // Row bookkeeping for the pixel at the input
  always_comb begin
    w_eff = cfg_i.row_width;
    if (w_eff == '0) begin
      w_eff = sthi_pkg::RW_W'(1);
    end else if (w_eff > sthi_pkg::RW_W'(sthi_pkg::MAX_WIDTH)) begin
      w_eff = sthi_pkg::RW_W'(sthi_pkg::MAX_WIDTH);
    end
    w_m1      = w_eff - sthi_pkg::RW_W'(1);
    col_eff   = frame_start_i ? '0 : column_count_q;
    first_eff = frame_start_i || first_row_q;
    is_col0   = (col_eff == '0);
    last      = ({1'b0, col_eff} >= w_m1);
    slope_sel = is_col0 ? col0_y_slope_q : prev_x_slope_q;
  end

  assign status_o.skip = is_col0 && first_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      first_row_q    <= 1'b1;
      prev_x_slope_q <= '0;
      col0_y_slope_q <= '0;
      row_height_q   <= '0;
      col0_height_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        prev_x_slope_q <= x_slope_i;
        if (is_col0) begin
          col0_y_slope_q <= y_slope_i;
        end
        if (last) begin
          column_count_q <= '0;
          first_row_q    <= 1'b0;
        end else begin
          column_count_q <= col_eff + sthi_pkg::CNT_W'(1);
          first_row_q    <= first_eff;
        end
      end
      if (cmd_i.load_out) begin
        row_height_q <= h_new;
        if (col0_q) begin
          col0_height_q <= h_new;
        end
      end
    end
  end

  // Latch the operands of this pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      prev_q  <= is_col0 ? col0_height_q : row_height_q;
      neg_q   <= slope_sel[sthi_pkg::SLOPE_W-1];
      mag_q   <= slope_sel[sthi_pkg::SLOPE_W-1]
               ? (sthi_pkg::MAG_W'(17'h10000) - {1'b0, slope_sel})
               : {1'b0, slope_sel};
      step_q  <= is_col0 ? cfg_i.step_y : cfg_i.step_x;
      scale_q <= is_col0 ? cfg_i.inv_scale_y : cfg_i.inv_scale_x;
      zero_q  <= status_o.skip;
      col0_q  <= is_col0;
      last_q  <= last;
    end
  end

  // Shared multiplier operands
  always_comb begin
    unique case (cmd_i.op)
      sthi_pkg::OP_ANGLE: begin
        mul_a = sthi_pkg::MUL_W'(mag_q);
        mul_b = scale_q;
      end
      sthi_pkg::OP_SQUARE: begin
        mul_a = sthi_pkg::MUL_W'(a_q);
        mul_b = sthi_pkg::MUL_W'(a_q);
      end
      sthi_pkg::OP_HORNER: begin
        mul_a = acc_q;
        mul_b = sthi_pkg::MUL_W'(x2_q);
      end
      sthi_pkg::OP_TAN: begin
        mul_a = acc_q;
        mul_b = sthi_pkg::MUL_W'(a_q);
      end
      sthi_pkg::OP_STEP: begin
        mul_a = sthi_pkg::MUL_W'(step_q);
        mul_b = t_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign a_raw = prod_q[48:18];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.wb_en) begin
      case (cmd_i.op)
        sthi_pkg::OP_ANGLE: begin
          // Clamp the angle magnitude to pi/4
          a_q <= (a_raw > {1'b0, sthi_pkg::PI4_Q30}) ? sthi_pkg::PI4_Q30
                                                     : a_raw[sthi_pkg::ANG_W-1:0];
        end
        sthi_pkg::OP_SQUARE: begin
          x2_q  <= prod_q[59:30];
          acc_q <= sthi_pkg::tan_coef(3'd0);
        end
        sthi_pkg::OP_HORNER: acc_q <= sthi_pkg::tan_coef(cmd_i.coef_idx) + prod_q[61:30];
        sthi_pkg::OP_TAN:    t_q <= prod_q[61:30];
        sthi_pkg::OP_STEP:   d_q <= prod_q[sthi_pkg::D_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.sum_en) begin
      sum_q <= neg_q ? (prev_sh - d_ext) : (prev_sh + d_ext);
    end
    if (cmd_i.load_out) begin
      height_q  <= h_new;
      row_end_q <= last_q;
    end
  end

  assign prev_sh = {{2{prev_q[sthi_pkg::HEIGHT_W-1]}}, prev_q, 30'b0};
  assign d_ext   = {13'b0, d_q};

  // Divide by 2^30 truncating toward zero, then saturate to 32 bits
  always_comb begin
    quot     = sum_q[63:30];
    quot_adj = quot + {33'b0, (sum_q[63] && (|sum_q[29:0]))};
    if (!quot_adj[33] && (|quot_adj[32:31])) begin
      h_sat = 32'sh7FFF_FFFF;
    end else if (quot_adj[33] && !(&quot_adj[32:31])) begin
      h_sat = 32'sh8000_0000;
    end else begin
      h_sat = quot_adj[31:0];
    end
    h_new = zero_q ? '0 : h_sat;
  end

  assign height_o  = height_q;
  assign row_end_o = row_end_q;

endmodule

/* rtl/slope_to_height_integrator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_to_height_integrator_unit: height map from raster slope samples
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Each pixel transfer yields exactly one height transfer, in order. The block
// works on one pixel at a time and holds in_stall_o high from a pixel transfer
// until that pixel's height is loaded into the output register. A pixel that
// starts a frame (frame_start set, or the first pixel after reset) skips the
// multiplier and goes straight to the final step, where it is loaded once
// the output register is free. Every other pixel makes eleven dependent
// passes through the one shared 32x32 multiplier (angle, angle squared, seven
// Horner steps of the tangent, tangent, step scaling), each pass a multiply
// step and a writeback step, then a sum step, and is loaded in the final
// step, with the divide-and-saturate, once the output register is free. The
// next pixel is taken in only in the idle step after that load. A height
// that is still stalled in the output register holds the block in the final
// step. A finished height sits in the output register while the next
// pixel is already taken in. Registers are written at any time the port is
// valid (the port never pushes back) but must only change while no pixel is
// in flight.
// ----------------------------------------------------------------------------
module slope_to_height_integrator_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // pixel input
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [sthi_pkg::SLOPE_W-1:0]     x_slope_i,
  input  logic signed [sthi_pkg::SLOPE_W-1:0]     y_slope_i,
  input  logic                                    frame_start_i,
  // height output
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [sthi_pkg::HEIGHT_W-1:0]    height_o,
  output logic                                    row_end_o,
  // register writes
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [sthi_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [sthi_pkg::CFG_DAT_W-1:0]          cfg_data_i
);

  sthi_pkg::cfg_t       cfg_q;
  sthi_pkg::ctrl_cmd_t  cmd;
  sthi_pkg::dp_status_t status;

  // The register file always takes a write.
  assign cfg_ready_o = 1'b1;

  // Register file: drop writes to indexes beyond the map.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width   <= sthi_pkg::RST_ROW_WIDTH;
      cfg_q.step_x      <= sthi_pkg::RST_STEP_X;
      cfg_q.step_y      <= sthi_pkg::RST_STEP_Y;
      cfg_q.inv_scale_x <= sthi_pkg::RST_INV_SCALE_X;
      cfg_q.inv_scale_y <= sthi_pkg::RST_INV_SCALE_Y;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sthi_pkg::REG_ROW_WIDTH:   cfg_q.row_width   <= cfg_data_i[sthi_pkg::RW_W-1:0];
        sthi_pkg::REG_STEP_X:      cfg_q.step_x      <= cfg_data_i[sthi_pkg::STEP_W-1:0];
        sthi_pkg::REG_STEP_Y:      cfg_q.step_y      <= cfg_data_i[sthi_pkg::STEP_W-1:0];
        sthi_pkg::REG_INV_SCALE_X: cfg_q.inv_scale_x <= cfg_data_i;
        sthi_pkg::REG_INV_SCALE_Y: cfg_q.inv_scale_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: one pixel in flight, output register handshake
  sthi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: raster state, shared multiplier, height update
  sthi_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .x_slope_i     (x_slope_i),
    .y_slope_i     (y_slope_i),
    .frame_start_i (frame_start_i),
    .height_o      (height_o),
    .row_end_o     (row_end_o)
  );

endmodule

/* rtl/sthi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthi_checker: port-level checks of the slope-to-height integrator
// Watches the pixel and height channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sthi_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 frame_start_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [sthi_pkg::HEIGHT_W-1:0] height_o,
  input logic                                 row_end_o
);

  // One pixel in flight: block input after each transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a pixel is in flight");

  // A stalled height holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(height_o) && $stable(row_end_o)))
    else $error("stalled height changed");

  // A new height only appears after a pixel was in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("height produced without a pixel");

  // A frame start taken while the output is free gives height zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && frame_start_i && !out_valid_o) |->
      ##2 (out_valid_o && (height_o == '0)))
    else $error("frame start did not yield height zero");

endmodule

bind slope_to_height_integrator_unit sthi_checker u_sthi_checker (.*);

/* bench/slope_to_height_integrator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_to_height_integrator_unit_tb: self-checking bench for the integrator
// Streams raster pixels through the block under several register settings and
// random handshake pressure. A local model predicts each height and row-end
// flag, and every height transfer is checked in order against it.
// ----------------------------------------------------------------------------
module slope_to_height_integrator_unit_tb;
  import sthi_pkg::*;

  // Odd Taylor terms of tan in Q30, index 0 is the x^15 term.
  localparam logic [7:0][31:0] TAN_TERMS = {
    32'd1073741824, 32'd357913941, 32'd143165577, 32'd57947971,
    32'd23482185, 32'd9516827, 32'd3857018, 32'd1563190
  };
  localparam longint ONE_Q30   = 64'sd1073741824;
  localparam longint HEIGHT_HI = 64'sd2147483647;
  localparam longint HEIGHT_LO = -64'sd2147483648;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    logic                       row_end;
  } pixel_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [SLOPE_W-1:0]  x_slope_i = '0;
  logic signed [SLOPE_W-1:0]  y_slope_i = '0;
  logic                       frame_start_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [HEIGHT_W-1:0] height_o;
  logic                       row_end_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]       cfg_data_i = '0;

  // Handshake pressure, in percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;

  // Expected heights, oldest first.
  pixel_result_t height_q[$];
  pixel_result_t next_height;

  // Local copy of the registers and of the raster state.
  cfg_t                       cfg_q;
  logic [CNT_W-1:0]           col_cnt = '0;
  logic                       on_first_row = 1'b1;
  logic [SLOPE_W-1:0]         left_x_slope = '0;
  logic signed [HEIGHT_W-1:0] left_height = '0;
  logic signed [HEIGHT_W-1:0] top_height = '0;
  logic [SLOPE_W-1:0]         top_y_slope = '0;

  slope_to_height_integrator_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_slope_i    (x_slope_i),
    .y_slope_i    (y_slope_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .height_o     (height_o),
    .row_end_o    (row_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Height model
  // --------------------------------------------------------------------------

  // Clamp the programmed width the way the block does: zero acts as one,
  // anything past the counter range acts as the full range.
  function automatic int unsigned row_len(input logic [RW_W-1:0] rw);
    if (rw == 0) return 1;
    if (rw > MAX_WIDTH) return MAX_WIDTH;
    return rw;
  endfunction

  // Q30 tangent of a non-negative Q30 angle, angle clamped to pi/4.
  function automatic logic [63:0] tan_q30(input logic [63:0] ang);
    logic [63:0] a, x2, acc;
    a = (ang > 64'(PI4_Q30)) ? 64'(PI4_Q30) : ang;
    x2 = (a * a) >> 30;
    acc = 64'(TAN_TERMS[0]);
    for (int k = 1; k < 8; k++)
      acc = 64'(TAN_TERMS[k]) + ((acc * x2) >> 30);
    return (acc * a) >> 30;
  endfunction

  // base + step*tan(slope*scale), truncated toward zero and saturated.
  function automatic logic signed [HEIGHT_W-1:0] integrate(
    input logic signed [HEIGHT_W-1:0] base,
    input logic [SLOPE_W-1:0]         slope,
    input logic [STEP_W-1:0]          step,
    input logic [SCALE_W-1:0]         scale
  );
    logic [63:0] mag, ang, incr;
    longint      sum, quo;
    // Take the magnitude on 17 bits so the most negative slope stays exact.
    mag = slope[SLOPE_W-1] ? 64'(17'h10000 - 17'(slope)) : 64'(slope);
    ang = (mag * 64'(scale)) >> 18;
    incr = 64'(step) * tan_q30(ang);
    sum = longint'(base) * ONE_Q30 + (slope[SLOPE_W-1] ? -longint'(incr) : longint'(incr));
    quo = sum / ONE_Q30;
    if (quo > HEIGHT_HI) quo = HEIGHT_HI;
    if (quo < HEIGHT_LO) quo = HEIGHT_LO;
    return quo[HEIGHT_W-1:0];
  endfunction

  // Advance the raster state by one accepted pixel and queue its height.
  function automatic void predict_height(
    input logic [SLOPE_W-1:0] xs,
    input logic [SLOPE_W-1:0] ys,
    input logic               fs
  );
    int unsigned   w;
    pixel_result_t r;
    w = row_len(cfg_q.row_width);
    if (fs) begin
      col_cnt = '0;
      on_first_row = 1'b1;
    end
    if (col_cnt == 0) begin
      // Column zero hangs off the pixel above, not the pixel to the left.
      if (on_first_row) r.height = '0;
      else r.height = integrate(top_height, top_y_slope, cfg_q.step_y, cfg_q.inv_scale_y);
      top_height = r.height;
      top_y_slope = ys;
    end else begin
      r.height = integrate(left_height, left_x_slope, cfg_q.step_x, cfg_q.inv_scale_x);
    end
    left_height = r.height;
    left_x_slope = xs;
    // A width shrunk below the current column ends the row right here.
    r.row_end = (col_cnt >= w - 1);
    if (r.row_end) begin
      col_cnt = '0;
      on_first_row = 1'b0;
    end else begin
      col_cnt++;
    end
    height_q.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one pixel, with random idle cycles ahead of it. Valid stays high
  // after the transfer so back-to-back pixels need no second assignment.
  task automatic send_pixel(
    input logic [SLOPE_W-1:0] xs,
    input logic [SLOPE_W-1:0] ys,
    input logic               fs
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    x_slope_i     <= xs;
    y_slope_i     <= ys;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    predict_height(xs, ys, fs);
  endtask

  // Drop valid and hold until every queued height has been checked.
  task automatic drain_heights();
    in_valid_i <= 1'b0;
    while (height_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ROW_WIDTH:   cfg_q.row_width   = data[RW_W-1:0];
      REG_STEP_X:      cfg_q.step_x      = data[STEP_W-1:0];
      REG_STEP_Y:      cfg_q.step_y      = data[STEP_W-1:0];
      REG_INV_SCALE_X: cfg_q.inv_scale_x = data[SCALE_W-1:0];
      REG_INV_SCALE_Y: cfg_q.inv_scale_y = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Write the whole register set; only call this with the block idle.
  task automatic load_config(input cfg_t c);
    write_reg(REG_ROW_WIDTH,   32'(c.row_width));
    write_reg(REG_STEP_X,      32'(c.step_x));
    write_reg(REG_STEP_Y,      32'(c.step_y));
    write_reg(REG_INV_SCALE_X, c.inv_scale_x);
    write_reg(REG_INV_SCALE_Y, c.inv_scale_y);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random values, biased toward the extremes
  // --------------------------------------------------------------------------

  function automatic logic [SLOPE_W-1:0] rand_slope();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      3:       return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 20'd1000000;
      2:       return RST_STEP_X;
      default: return 20'($urandom_range(0, 1000000));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return RST_INV_SCALE_X;
      3:       return RST_INV_SCALE_Y;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    case ($urandom_range(0, 9))
      0:       c.row_width = '0;
      1:       c.row_width = 13'($urandom_range(MAX_WIDTH + 1, 8191));
      2, 3:    c.row_width = 13'($urandom_range(13, 64));
      default: c.row_width = 13'($urandom_range(1, 12));
    endcase
    c.step_x      = rand_step();
    c.step_y      = rand_step();
    c.inv_scale_x = rand_scale();
    c.inv_scale_y = rand_scale();
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Run on reset values without a leading frame_start, then restart the
  // frame in the middle of a row.
  task automatic test_start_without_frame();
    send_pixel(16'h7FFF, 16'h8000, 1'b0);
    send_pixel(16'h8000, 16'h7FFF, 1'b0);
    send_pixel(16'h0000, 16'h0000, 1'b0);
    send_pixel(16'h7FFF, 16'h7FFF, 1'b0);
    send_pixel(16'h8000, 16'h8000, 1'b1);
    send_pixel(16'h1234, 16'hEDCB, 1'b0);
    send_pixel(16'hFFFF, 16'h0001, 1'b0);
    drain_heights();
  endtask

  // Width clamped at the low end, a width cut below the current column,
  // and the zero step and zero scale corners.
  task automatic test_row_width_limits();
    cfg_t c;
    c = '{row_width: '0, step_x: 20'd1000000, step_y: 20'd1000000,
          inv_scale_x: 32'hFFFF_FFFF, inv_scale_y: 32'hFFFF_FFFF};
    load_config(c);
    send_pixel(16'h0000, 16'h7FFF, 1'b1);
    send_pixel(16'h0000, 16'h8000, 1'b0);
    send_pixel(16'h7FFF, 16'h7FFF, 1'b0);
    send_pixel(16'h8000, 16'h0000, 1'b0);
    drain_heights();

    // Stop five pixels into an eight-wide row, then shrink it to three.
    c.row_width = 13'd8;
    load_config(c);
    send_pixel(16'h7FFF, 16'h8000, 1'b1);
    for (int i = 0; i < 4; i++) send_pixel(16'h8000, 16'h7FFF, 1'b0);
    drain_heights();
    c.row_width = 13'd3;
    load_config(c);
    send_pixel(16'h7FFF, 16'h0100, 1'b0);
    send_pixel(16'h8000, 16'h0200, 1'b0);
    drain_heights();

    c = '{row_width: 13'd2, step_x: '0, step_y: '0, inv_scale_x: '0, inv_scale_y: '0};
    load_config(c);
    for (int i = 0; i < 4; i++) send_pixel(16'h7FFF, 16'h8000, 1'b0);
    drain_heights();
  endtask

  // Segments of well-formed frames with random content, each under a fresh
  // register set, mixed with missing and stray frame starts.
  task automatic test_random_stream(
    input int unsigned send_pct,
    input int unsigned recv_pct,
    input int unsigned n_items
  );
    int unsigned sent, w, npx, cap;
    cfg_t        c;
    logic        fs;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      drain_heights();
      c = random_config();
      load_config(c);
      w = row_len(c.row_width);
      cap = (w > 40) ? 40 : w;
      repeat ($urandom_range(1, 3)) begin
        if (w > 40) npx = $urandom_range(1, 40);
        else npx = w * $urandom_range(1, 4);
        // Leave a row unfinished now and then, so the next frame cuts it.
        if ($urandom_range(0, 4) == 0) npx += $urandom_range(1, cap);
        for (int i = 0; i < npx; i++) begin
          if (i == 0) fs = ($urandom_range(0, 9) != 0);
          else fs = ($urandom_range(0, 49) == 0);
          send_pixel(rand_slope(), rand_slope(), fs);
        end
        sent += npx;
      end
    end
    drain_heights();
  endtask

  // --------------------------------------------------------------------------
  // Height checker and receiver pressure
  // --------------------------------------------------------------------------

  // Compare every height transfer with the oldest prediction, then pick the
  // stall for the next cycle. Signals read here hold their pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (height_q.size() == 0) begin
        $display("%0t: unexpected height transfer: expected none, actual height %0d row_end %0b",
                 $time, height_o, row_end_o);
        error_count++;
      end else begin
        next_height = height_q.pop_front();
        if (height_o !== next_height.height) begin
          $display("%0t: height mismatch: expected %0d, actual %0d",
                   $time, next_height.height, height_o);
          error_count++;
        end
        if (row_end_o !== next_height.row_end) begin
          $display("%0t: row_end mismatch: expected %0b, actual %0b",
                   $time, next_height.row_end, row_end_o);
          error_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    cfg_q.row_width   = RST_ROW_WIDTH;
    cfg_q.step_x      = RST_STEP_X;
    cfg_q.step_y      = RST_STEP_Y;
    cfg_q.inv_scale_x = RST_INV_SCALE_X;
    cfg_q.inv_scale_y = RST_INV_SCALE_Y;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 79;
    test_start_without_frame();
    test_row_width_limits();

    // Sender light and receiver heavy, then swapped, then full rate.
    test_random_stream(36, 79, 590);
    test_random_stream(79, 36, 580);
    test_random_stream(0, 0, 580);

    // Allow a stray late transfer to show up before the verdict.
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("slope_to_height_integrator_unit_tb: clean");
    end else begin
      $display("slope_to_height_integrator_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost height ends the run here.
  initial begin
    #40_000_000;
    $display("slope_to_height_integrator_unit_tb: errors");
    $finish;
  end

endmodule
